@@ src/rigid_body_euler_integrator_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the rigid body Euler integrator
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef RIGID_BODY_EULER_INTEGRATOR_DEFINES_SVH
`define RIGID_BODY_EULER_INTEGRATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RBEI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) \
        else $error(msg);

`define RBEI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
        else $error(msg);

`else

`define RBEI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define RBEI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/rbei_pkg.sv @@
// ---------------------------------------------------------------------------
// Rigid body Euler integrator package
// Shared types, codes and saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package rbei_pkg;

    localparam int PIPE_DEPTH = 9;
    localparam int WIDE_W     = 68;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [1:0]               mode_t;

    localparam mode_t MODE_PASS = 2'd0;
    localparam mode_t MODE_KIN  = 2'd1;
    localparam mode_t MODE_DYN  = 2'd2;

    localparam logic [1:0] KIND_KINEMATIC = 2'd2;
    localparam logic [1:0] KIND_DYNAMIC   = 2'd3;

    localparam logic [1:0] REG_STEP_TIME = 2'd0;
    localparam logic [1:0] REG_GRAVITY_X = 2'd1;
    localparam logic [1:0] REG_GRAVITY_Y = 2'd2;

    localparam logic [15:0]        STEP_TIME_RESET = 16'd1092;
    localparam logic signed [33:0] ONE_Q16         = 34'sd65536;

    function automatic logic sat_hit(input wide_t v);
        return !((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]));
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        if (sat_hit(v))
        begin
            r = v[WIDE_W-1] ? 32'sh80000000 : 32'sh7fffffff;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/rigid_body_euler_integrator.sv @@
// ---------------------------------------------------------------------------
// Rigid body Euler integrator
// Semi-implicit Euler step with damping for one 2D body per word.
// ---------------------------------------------------------------------------
// A body word is taken at every clock edge with start high; busy never rises,
// so one word per cycle streams in without gaps. Each result passes through
// the nine-stage multiply pipeline (force sum, acceleration product, velocity
// update, damping product, position update) and is shown for one cycle with
// done high; the receiver cannot stall it. Write step time and gravity only
// while no word is in flight.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rigid_body_euler_integrator_defines.svh"

module rigid_body_euler_integrator
    import rbei_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cfg_write,
    input  wire logic        [1:0]  cfg_index,
    input  wire logic        [31:0] cfg_data,
    input  wire logic               body_valid,
    input  wire logic        [1:0]  body_kind,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic signed [31:0] force_x,
    input  wire logic signed [31:0] force_y,
    input  wire logic        [31:0] inverse_mass,
    input  wire logic        [31:0] damping,
    output logic                    done,
    output logic signed      [31:0] new_pos_x,
    output logic signed      [31:0] new_pos_y,
    output logic signed      [31:0] new_vel_x,
    output logic signed      [31:0] new_vel_y,
    output logic                    forces_cleared,
    output logic                    saturated
);

    logic        [15:0]           step_time_reg;
    logic signed [31:0]           gravity_x_reg;
    logic signed [31:0]           gravity_y_reg;
    logic                         accept;
    mode_t                        mode;
    logic        [PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic        [PIPE_DEPTH-1:0] dyn_reg, dyn_next;
    logic        [47:0]           dd_s1_next, dd_s1_reg;
    logic signed [33:0]           k_s2_next, k_s2_reg, k_s3_reg, k_s4_reg, k_s5_reg;
    logic                         sat_x, sat_y;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        if (!body_valid)
        begin
            mode = MODE_PASS;
        end
        else
        begin
            case (body_kind)
                KIND_DYNAMIC:   mode = MODE_DYN;
                KIND_KINEMATIC: mode = MODE_KIN;
                default:        mode = MODE_PASS;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= STEP_TIME_RESET;
            gravity_x_reg <= '0;
            gravity_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_STEP_TIME: step_time_reg <= cfg_data[15:0];
                REG_GRAVITY_X: gravity_x_reg <= cfg_data;
                REG_GRAVITY_Y: gravity_y_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], accept};
    assign dyn_next   = {dyn_reg[PIPE_DEPTH-2:0], mode == MODE_DYN};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // damping factor k = 1 - damping * dt, shared by both axes
    assign dd_s1_next = 48'(damping) * 48'(step_time_reg);
    assign k_s2_next  = ONE_Q16 - $signed({2'b00, dd_s1_reg[47:16]});

    always_ff @(posedge clk)
    begin
        dyn_reg   <= dyn_next;
        dd_s1_reg <= dd_s1_next;
        k_s2_reg  <= k_s2_next;
        k_s3_reg  <= k_s2_reg;
        k_s4_reg  <= k_s3_reg;
        k_s5_reg  <= k_s4_reg;
    end

    rbei_axis u_axis_x
    (
        .clk      (clk),
        .mode     (mode),
        .pos      (pos_x),
        .vel      (vel_x),
        .frc      (force_x),
        .grav     (gravity_x_reg),
        .invm     (inverse_mass),
        .dt       (step_time_reg),
        .k_s5     (k_s5_reg),
        .new_pos  (new_pos_x),
        .new_vel  (new_vel_x),
        .sat_flag (sat_x)
    );

    rbei_axis u_axis_y
    (
        .clk      (clk),
        .mode     (mode),
        .pos      (pos_y),
        .vel      (vel_y),
        .frc      (force_y),
        .grav     (gravity_y_reg),
        .invm     (inverse_mass),
        .dt       (step_time_reg),
        .k_s5     (k_s5_reg),
        .new_pos  (new_pos_y),
        .new_vel  (new_vel_y),
        .sat_flag (sat_y)
    );

    assign done           = valid_reg[PIPE_DEPTH-1];
    assign forces_cleared = done && dyn_reg[PIPE_DEPTH-1];
    assign saturated      = done && (sat_x || sat_y);

    `RBEI_ASSERT_IMPL(a_latency, clk, rst_n, accept, ##PIPE_DEPTH done,
        "accepted word produced no result at the pipeline depth")
    `RBEI_ASSERT_IMPL(a_no_spurious, clk, rst_n, done, $past(accept, PIPE_DEPTH),
        "result without a matching accepted word")
    `RBEI_ASSERT_IMPL(a_vel_hold, clk, rst_n, done && !forces_cleared,
        new_vel_x == $past(vel_x, PIPE_DEPTH),
        "velocity changed on a non-dynamic body")
    `RBEI_ASSERT_NEXT(a_invalid_pass, clk, rst_n, accept && !body_valid,
        ##(PIPE_DEPTH-1) (new_pos_y == $past(pos_y, PIPE_DEPTH) && !saturated),
        "invalid body did not pass through")

endmodule

`default_nettype wire

@@ src/rbei_axis.sv @@
// ---------------------------------------------------------------------------
// Rigid body Euler integrator, one axis
// Nine-stage datapath: force sum, acceleration, velocity, damping, position.
// ---------------------------------------------------------------------------
`default_nettype none

module rbei_axis
    import rbei_pkg::*;
(
    input  wire logic               clk,
    input  wire mode_t              mode,
    input  wire logic signed [31:0] pos,
    input  wire logic signed [31:0] vel,
    input  wire logic signed [31:0] frc,
    input  wire logic signed [31:0] grav,
    input  wire logic        [31:0] invm,
    input  wire logic        [15:0] dt,
    input  wire logic signed [33:0] k_s5,
    output logic signed      [31:0] new_pos,
    output logic signed      [31:0] new_vel,
    output logic                    sat_flag
);

    mode_t              s1_mode_reg, s2_mode_reg, s3_mode_reg, s4_mode_reg;
    mode_t              s5_mode_reg, s6_mode_reg, s7_mode_reg, s8_mode_reg;
    logic signed [31:0] s1_pos_reg, s2_pos_reg, s3_pos_reg, s4_pos_reg;
    logic signed [31:0] s5_pos_reg, s6_pos_reg, s7_pos_reg, s8_pos_reg;
    logic signed [31:0] s1_vel_reg, s2_vel_reg, s3_vel_reg, s4_vel_reg;
    logic signed [31:0] s5_vel_reg, s6_vel_reg;
    logic               s1_flag_reg, s2_flag_reg, s3_flag_reg, s4_flag_reg;
    logic               s5_flag_reg, s6_flag_reg, s7_flag_reg, s8_flag_reg;

    wide_t              s1_sum;
    logic signed [31:0] s1_f_next, s1_f_reg;
    logic        [31:0] s1_invm_reg;
    logic signed [64:0] s2_fm_next, s2_fm_reg;
    wide_t              s3_shift;
    logic signed [31:0] s3_a_next, s3_a_reg;
    logic signed [48:0] s4_adt_next, s4_adt_reg;
    wide_t              s5_sum;
    logic signed [31:0] s5_v1_next, s5_v1_reg;
    logic signed [65:0] s6_vk_next, s6_vk_reg;
    wide_t              s7_shift;
    logic signed [31:0] s7_v2_next, s7_v2_reg;
    logic               s7_flag_next;
    logic signed [48:0] s8_pd_next, s8_pd_reg;
    logic signed [31:0] s8_vel_reg;
    wide_t              s9_sum;
    logic signed [31:0] s9_pos_next, s9_pos_reg;
    logic signed [31:0] s9_vel_reg;
    logic               s9_flag_next, s9_flag_reg;

    assign s1_sum      = wide_t'(frc) + wide_t'(grav);
    assign s1_f_next   = sat32(s1_sum);
    assign s2_fm_next  = 65'(s1_f_reg) * 65'($signed({1'b0, s1_invm_reg}));
    assign s3_shift    = wide_t'(s2_fm_reg >>> 16);
    assign s3_a_next   = sat32(s3_shift);
    assign s4_adt_next = 49'(s3_a_reg) * 49'($signed({1'b0, dt}));
    assign s5_sum      = wide_t'(s4_vel_reg) + wide_t'(s4_adt_reg >>> 16);
    assign s5_v1_next  = sat32(s5_sum);
    assign s6_vk_next  = 66'(s5_v1_reg) * 66'(k_s5);
    assign s7_shift    = wide_t'(s6_vk_reg >>> 16);
    assign s8_pd_next  = 49'(s7_v2_reg) * 49'($signed({1'b0, dt}));
    assign s9_sum      = wide_t'(s8_pos_reg) + wide_t'(s8_pd_reg >>> 16);

    always_comb
    begin
        if (s6_mode_reg == MODE_DYN)
        begin
            s7_v2_next   = sat32(s7_shift);
            s7_flag_next = s6_flag_reg | sat_hit(s7_shift);
        end
        else
        begin
            s7_v2_next   = s6_vel_reg;
            s7_flag_next = s6_flag_reg;
        end
    end

    always_comb
    begin
        case (s8_mode_reg)
            MODE_DYN:
            begin
                s9_pos_next  = sat32(s9_sum);
                s9_flag_next = s8_flag_reg | sat_hit(s9_sum);
            end
            MODE_KIN:
            begin
                s9_pos_next  = sat32(s9_sum);
                s9_flag_next = sat_hit(s9_sum);
            end
            default:
            begin
                s9_pos_next  = s8_pos_reg;
                s9_flag_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= mode;
        s1_pos_reg  <= pos;
        s1_vel_reg  <= vel;
        s1_f_reg    <= s1_f_next;
        s1_invm_reg <= invm;
        s1_flag_reg <= sat_hit(s1_sum);

        s2_mode_reg <= s1_mode_reg;
        s2_pos_reg  <= s1_pos_reg;
        s2_vel_reg  <= s1_vel_reg;
        s2_fm_reg   <= s2_fm_next;
        s2_flag_reg <= s1_flag_reg;

        s3_mode_reg <= s2_mode_reg;
        s3_pos_reg  <= s2_pos_reg;
        s3_vel_reg  <= s2_vel_reg;
        s3_a_reg    <= s3_a_next;
        s3_flag_reg <= s2_flag_reg | sat_hit(s3_shift);

        s4_mode_reg <= s3_mode_reg;
        s4_pos_reg  <= s3_pos_reg;
        s4_vel_reg  <= s3_vel_reg;
        s4_adt_reg  <= s4_adt_next;
        s4_flag_reg <= s3_flag_reg;

        s5_mode_reg <= s4_mode_reg;
        s5_pos_reg  <= s4_pos_reg;
        s5_vel_reg  <= s4_vel_reg;
        s5_v1_reg   <= s5_v1_next;
        s5_flag_reg <= s4_flag_reg | sat_hit(s5_sum);

        s6_mode_reg <= s5_mode_reg;
        s6_pos_reg  <= s5_pos_reg;
        s6_vel_reg  <= s5_vel_reg;
        s6_vk_reg   <= s6_vk_next;
        s6_flag_reg <= s5_flag_reg;

        s7_mode_reg <= s6_mode_reg;
        s7_pos_reg  <= s6_pos_reg;
        s7_v2_reg   <= s7_v2_next;
        s7_flag_reg <= s7_flag_next;

        s8_mode_reg <= s7_mode_reg;
        s8_pos_reg  <= s7_pos_reg;
        s8_vel_reg  <= s7_v2_reg;
        s8_pd_reg   <= s8_pd_next;
        s8_flag_reg <= s7_flag_reg;

        s9_pos_reg  <= s9_pos_next;
        s9_vel_reg  <= s8_vel_reg;
        s9_flag_reg <= s9_flag_next;
    end

    assign new_pos  = s9_pos_reg;
    assign new_vel  = s9_vel_reg;
    assign sat_flag = s9_flag_reg;

endmodule

`default_nettype wire
